[rtl/bos_pkg.sv]
// Shared constants, types and tables of the box overlap score block.
package bos_pkg;

  // Configuration port
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 8;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCORE_VARIANT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_EPS_GUARD     = 2'd2;

  typedef enum logic [1:0] {
    VAR_IOU  = 2'd0,
    VAR_GIOU = 2'd1,
    VAR_DIOU = 2'd2,
    VAR_CIOU = 2'd3
  } score_variant_e;

  // Quotient magnitude bits; quotients cap at 2^(QUO_BITS-1)
  localparam int QUO_BITS    = 41;
  localparam int DIV_LATENCY = QUO_BITS + 2;

  // Arctangent unit: angles in units of pi/2, scaled by 2^ANG_BITS
  localparam int ANG_BITS         = 20;
  localparam int ANG_STEPS        = 20;
  localparam int ANG_WIDTH        = 23;
  localparam int CORDIC_PRE_SHIFT = 24;

  localparam logic signed [ANG_WIDTH-1:0] ATAN_TAB [ANG_STEPS] = '{
    23'sd524288, 23'sd309505, 23'sd163534, 23'sd83012, 23'sd41667,
    23'sd20854,  23'sd10430,  23'sd5215,   23'sd2608,  23'sd1304,
    23'sd652,    23'sd326,    23'sd163,    23'sd81,    23'sd41,
    23'sd20,     23'sd10,     23'sd5,      23'sd3,     23'sd1
  };

endpackage

[rtl/bos_box_if.sv]
// Input channel: one pair of boxes per item.
interface bos_box_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_coord_0;
  logic signed [COORD_WIDTH-1:0] first_coord_1;
  logic signed [COORD_WIDTH-1:0] first_coord_2;
  logic signed [COORD_WIDTH-1:0] first_coord_3;
  logic signed [COORD_WIDTH-1:0] second_coord_0;
  logic signed [COORD_WIDTH-1:0] second_coord_1;
  logic signed [COORD_WIDTH-1:0] second_coord_2;
  logic signed [COORD_WIDTH-1:0] second_coord_3;

  modport source (
    output valid, first_coord_0, first_coord_1, first_coord_2, first_coord_3,
    output second_coord_0, second_coord_1, second_coord_2, second_coord_3,
    input  ready
  );
  modport sink (
    input  valid, first_coord_0, first_coord_1, first_coord_2, first_coord_3,
    input  second_coord_0, second_coord_1, second_coord_2, second_coord_3,
    output ready
  );
endinterface

[rtl/bos_score_if.sv]
// Output channel: one overlap score per item.
interface bos_score_if #(
  parameter int SCORE_WIDTH = 18
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SCORE_WIDTH-1:0] overlap_score;

  modport source (output valid, overlap_score, input ready);
  modport sink   (input valid, overlap_score, output ready);
endinterface

[rtl/bos_div.sv]
// Pipelined restoring divider, one quotient bit per stage, capped quotient.
module bos_div import bos_pkg::*; #(
  parameter int NUM_WIDTH = 57,
  parameter int DEN_WIDTH = 57,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [NUM_WIDTH-1:0]       num_i,
  input  logic                       neg_i,
  input  logic [DEN_WIDTH-1:0]       den_i,
  output logic signed [QUO_BITS:0]   quo_o
);

  localparam int QB  = QUO_BITS;
  localparam int NNW = NUM_WIDTH + FRAC_BITS;
  localparam int NNX = (NNW > QB) ? NNW : QB + 1;
  localparam logic [QB-1:0] CAP = QB'(1) << (QB - 1);

  logic [NNX-1:0]       nn;
  logic                 ovf;

  logic [DEN_WIDTH-1:0] rem_q [QB+1];
  logic [DEN_WIDTH-1:0] rem_d [QB+1];
  logic [DEN_WIDTH-1:0] den_q [QB+1];
  logic [QB-1:0]        lo_q  [QB+1];
  logic [QB-1:0]        lo_d  [QB+1];
  logic [QB-1:0]        quo_q [QB+1];
  logic [QB-1:0]        quo_d [QB+1];
  logic                 neg_q [QB+1];
  logic                 ovf_q [QB+1];

  logic [QB-1:0]        mag;
  logic signed [QB:0]   quo_q_out;

  assign nn  = NNX'(num_i) << FRAC_BITS;
  // quotient of 2^QB or more always caps
  assign ovf = (nn[NNX-1:QB] >= den_i);

  always_comb begin
    logic [DEN_WIDTH:0] t;
    rem_d[0] = '0;
    lo_d[0]  = '0;
    quo_d[0] = '0;
    for (int k = 1; k <= QB; k++) begin
      t = {rem_q[k-1], lo_q[k-1][QB-1]};
      if (t >= {1'b0, den_q[k-1]}) begin
        rem_d[k] = DEN_WIDTH'(t - {1'b0, den_q[k-1]});
        quo_d[k] = {quo_q[k-1][QB-2:0], 1'b1};
      end else begin
        rem_d[k] = DEN_WIDTH'(t);
        quo_d[k] = {quo_q[k-1][QB-2:0], 1'b0};
      end
      lo_d[k] = lo_q[k-1] << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_WIDTH'(nn[NNX-1:QB]);
      lo_q[0]  <= nn[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf;
      for (int k = 1; k <= QB; k++) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      quo_q_out <= neg_q[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign mag   = (ovf_q[QB] || (quo_q[QB] > CAP)) ? CAP : quo_q[QB];
  assign quo_o = quo_q_out;

endmodule

[rtl/box_overlap_score.sv]
// Box overlap score (IoU, GIoU, DIoU, CIoU) of one box pair per item, deep pipeline.
//
//   channel      dir  handshake       payload
//   box_pair_i   in   valid / ready   first_coord_0..3, second_coord_0..3 (Q11.4)
//   score_o      out  valid / ready   overlap_score (signed Q1.16, saturated)
//   cfg_*        in   cfg_we_i        cfg_idx_i selects register, cfg_wdata_i data
//
// One item enters per cycle while the pipeline is not held; it passes through five
// front stages, the IoU divider, one alpha stage, the CIoU alpha divider and the
// output register.
// Reset clears valid bits (output valid included) and the configuration registers.
// The whole pipeline holds only when its last stage has an item that cannot move
// into a full, stalled output register; otherwise bubbles drain and input flows.
module box_overlap_score import bos_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int SCORE_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bos_box_if.sink                   box_pair_i,
  bos_score_if.source               score_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  // Coordinates beyond 24 bits drop their low bits first
  localparam int CWE  = (COORD_WIDTH > 24) ? 24 : COORD_WIDTH;
  localparam int DROP = COORD_WIDTH - CWE;
  localparam int BW   = CWE + 2;           // doubled corners
  localparam int EW   = BW + 1;            // sides and extents
  localparam int SW   = EW + 1;            // center distance sums
  localparam int PW   = 2 * EW;            // side products
  localparam int XW   = PW + 3;            // sums, numerators, denominators
  localparam int KW   = EW + CORDIC_PRE_SHIFT + 2;
  localparam int DSW  = 2 * ANG_WIDTH;
  localparam int VSHIFT = 2 * ANG_BITS - SCORE_FRAC_BITS;
  localparam int VW   = DSW - VSHIFT;
  localparam int QB   = QUO_BITS;
  localparam int FW   = QB + 3;            // final score before saturation
  localparam int OW   = SCORE_FRAC_BITS + 2;
  localparam int LAT  = DIV_LATENCY;
  // pipeline positions: 0 corners, 1 sides, 2..21 arctangent, 24 aspect term
  localparam int V_IDX = ANG_STEPS + 4;
  localparam int V_DLY = 4 + LAT - V_IDX;
  localparam int NV    = 6 + 2 * LAT;

  localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] SAT_LO = ~SAT_HI;

  // ---------------------------------------------------------------- config
  logic           fmt_q;
  score_variant_e variant_q;
  logic [7:0]     guard_q;
  logic [7:0]     guard_eff;
  logic [8:0]     g2;
  logic [9:0]     g4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= 1'b0;
      variant_q <= VAR_IOU;
      guard_q   <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_FORMAT:    fmt_q     <= cfg_wdata_i[0];
        REG_SCORE_VARIANT: variant_q <= score_variant_e'(cfg_wdata_i[1:0]);
        REG_EPS_GUARD:     guard_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a zero guard behaves as one
  assign guard_eff = (guard_q == 8'd0) ? 8'd1 : guard_q;
  assign g2        = {guard_eff, 1'b0};
  assign g4        = {guard_eff, 2'b00};

  // ---------------------------------------------------------------- flow control
  logic          adv;
  logic [NV-1:0] vld_q;
  logic          out_vld_q;
  logic signed [OW-1:0] out_score_q;
  logic signed [OW-1:0] sat_score;

  // advance unless the oldest item is blocked by a stalled output register
  assign adv              = !vld_q[NV-1] || !out_vld_q || score_o.ready;
  assign box_pair_i.ready = adv;
  assign score_o.valid         = out_vld_q;
  assign score_o.overlap_score = out_score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NV-2:0], box_pair_i.valid};
      end
      if (adv && vld_q[NV-1]) begin
        out_vld_q <= 1'b1;
      end else if (score_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[NV-1]) begin
      out_score_q <= sat_score;
    end
  end

  // ---------------------------------------------------------------- stage 1: corners
  logic signed [CWE-1:0] crd [8];
  logic signed [BW-1:0]  cor_d [2][4];
  logic signed [BW-1:0]  cor_q [2][4];

  assign crd[0] = $signed(box_pair_i.first_coord_0[COORD_WIDTH-1:DROP]);
  assign crd[1] = $signed(box_pair_i.first_coord_1[COORD_WIDTH-1:DROP]);
  assign crd[2] = $signed(box_pair_i.first_coord_2[COORD_WIDTH-1:DROP]);
  assign crd[3] = $signed(box_pair_i.first_coord_3[COORD_WIDTH-1:DROP]);
  assign crd[4] = $signed(box_pair_i.second_coord_0[COORD_WIDTH-1:DROP]);
  assign crd[5] = $signed(box_pair_i.second_coord_1[COORD_WIDTH-1:DROP]);
  assign crd[6] = $signed(box_pair_i.second_coord_2[COORD_WIDTH-1:DROP]);
  assign crd[7] = $signed(box_pair_i.second_coord_3[COORD_WIDTH-1:DROP]);

  // everything is doubled so center-form half sizes stay exact
  always_comb begin
    for (int bx = 0; bx < 2; bx++) begin
      if (fmt_q) begin
        cor_d[bx][0] = (BW'(crd[4*bx]) <<< 1) - BW'(crd[4*bx+2]);
        cor_d[bx][1] = (BW'(crd[4*bx+1]) <<< 1) - BW'(crd[4*bx+3]);
        cor_d[bx][2] = (BW'(crd[4*bx]) <<< 1) + BW'(crd[4*bx+2]);
        cor_d[bx][3] = (BW'(crd[4*bx+1]) <<< 1) + BW'(crd[4*bx+3]);
      end else begin
        for (int j = 0; j < 4; j++) begin
          cor_d[bx][j] = BW'(crd[4*bx+j]) <<< 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: sides
  logic signed [EW-1:0] g2_e;
  logic signed [EW-1:0] w_d [2];
  logic signed [EW-1:0] h_d [2];
  logic signed [EW-1:0] w_q [2];
  logic signed [EW-1:0] h_q [2];
  logic signed [EW-1:0] iw_d, ih_d, cw_d, ch_d;
  logic signed [EW-1:0] iw_q, ih_q, cw_q, ch_q;
  logic signed [SW-1:0] sx_d, sy_d, sx_q, sy_q;

  assign g2_e = $signed(EW'(g2));

  always_comb begin
    logic signed [EW-1:0] hr, ix, iy;
    for (int bx = 0; bx < 2; bx++) begin
      w_d[bx] = EW'(cor_q[bx][2]) - EW'(cor_q[bx][0]);
      hr      = EW'(cor_q[bx][3]) - EW'(cor_q[bx][1]);
      // clamp heights to at least the guard
      h_d[bx] = (hr < g2_e) ? g2_e : hr;
    end
    ix = EW'((cor_q[0][2] < cor_q[1][2]) ? cor_q[0][2] : cor_q[1][2])
       - EW'((cor_q[0][0] > cor_q[1][0]) ? cor_q[0][0] : cor_q[1][0]);
    iy = EW'((cor_q[0][3] < cor_q[1][3]) ? cor_q[0][3] : cor_q[1][3])
       - EW'((cor_q[0][1] > cor_q[1][1]) ? cor_q[0][1] : cor_q[1][1]);
    iw_d = ix[EW-1] ? '0 : ix;
    ih_d = iy[EW-1] ? '0 : iy;
    // enclosing box runs from lowest low corner to highest high corner
    cw_d = EW'((cor_q[0][2] > cor_q[1][2]) ? cor_q[0][2] : cor_q[1][2])
         - EW'((cor_q[0][0] < cor_q[1][0]) ? cor_q[0][0] : cor_q[1][0]);
    ch_d = EW'((cor_q[0][3] > cor_q[1][3]) ? cor_q[0][3] : cor_q[1][3])
         - EW'((cor_q[0][1] < cor_q[1][1]) ? cor_q[0][1] : cor_q[1][1]);
    sx_d = SW'(cor_q[1][0]) + SW'(cor_q[1][2]) - SW'(cor_q[0][0]) - SW'(cor_q[0][2]);
    sy_d = SW'(cor_q[1][1]) + SW'(cor_q[1][3]) - SW'(cor_q[0][1]) - SW'(cor_q[0][3]);
  end

  // ---------------------------------------------------------------- stage 3: products
  logic signed [PW-1:0]   a1_q, a2_q, int_q, cwch_q, cw2_q, ch2_q;
  logic signed [PW+1:0]   sx2_q, sy2_q;

  // ---------------------------------------------------------------- stage 4: sums
  logic signed [XW-1:0]   uni_q, ca_q, c2x4_q, rho2_q, inter_q;

  // ---------------------------------------------------------------- stage 5: divider inputs
  logic [XW-1:0]          n1_q, d1_q, n2_q, d2_q;
  logic                   neg2_q;
  logic [XW-1:0]          n2_d, d2_d, d1_d;
  logic                   neg2_d;
  logic signed [XW-1:0]   gdiff;

  always_comb begin
    // non-positive denominators behave as one
    d1_d  = (uni_q[XW-1] || uni_q == '0) ? XW'(1) : uni_q;
    gdiff = ca_q - uni_q;
    if (variant_q == VAR_GIOU) begin
      neg2_d = gdiff[XW-1];
      n2_d   = gdiff[XW-1] ? -gdiff : gdiff;
      d2_d   = (ca_q[XW-1] || ca_q == '0) ? XW'(1) : ca_q;
    end else begin
      neg2_d = 1'b0;
      n2_d   = rho2_q;
      d2_d   = c2x4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q <= cor_d;
      w_q   <= w_d;
      h_q   <= h_d;
      iw_q  <= iw_d;
      ih_q  <= ih_d;
      cw_q  <= cw_d;
      ch_q  <= ch_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;

      a1_q   <= PW'(w_q[0]) * PW'(h_q[0]);
      a2_q   <= PW'(w_q[1]) * PW'(h_q[1]);
      int_q  <= PW'(iw_q) * PW'(ih_q);
      cwch_q <= PW'(cw_q) * PW'(ch_q);
      cw2_q  <= PW'(cw_q) * PW'(cw_q);
      ch2_q  <= PW'(ch_q) * PW'(ch_q);
      sx2_q  <= (PW+2)'(sx_q) * (PW+2)'(sx_q);
      sy2_q  <= (PW+2)'(sy_q) * (PW+2)'(sy_q);

      uni_q   <= XW'(a1_q) + XW'(a2_q) - XW'(int_q) + $signed(XW'(g4));
      ca_q    <= XW'(cwch_q) + $signed(XW'(g4));
      c2x4_q  <= (XW'(cw2_q) + XW'(ch2_q) + $signed(XW'(g4))) <<< 2;
      rho2_q  <= XW'(sx2_q) + XW'(sy2_q);
      inter_q <= XW'(int_q);

      n1_q   <= inter_q;
      d1_q   <= d1_d;
      n2_q   <= n2_d;
      d2_q   <= d2_d;
      neg2_q <= neg2_d;
    end
  end

  // ---------------------------------------------------------------- IoU and penalty dividers
  logic signed [QB:0] q1, q2, q3;

  bos_div #(
    .NUM_WIDTH (XW),
    .DEN_WIDTH (XW),
    .FRAC_BITS (SCORE_FRAC_BITS)
  ) u_div_iou (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n1_q),
    .neg_i (1'b0),
    .den_i (d1_q),
    .quo_o (q1)
  );

  // GIoU hull term, or the DIoU/CIoU distance term otherwise, picked by the variant register
  bos_div #(
    .NUM_WIDTH (XW),
    .DEN_WIDTH (XW),
    .FRAC_BITS (SCORE_FRAC_BITS)
  ) u_div_pen (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n2_q),
    .neg_i (neg2_q),
    .den_i (d2_q),
    .quo_o (q2)
  );

  // ---------------------------------------------------------------- aspect term
  // One CORDIC rotation per stage for each box, runs beside the dividers.
  logic signed [KW-1:0]        cx_q [2][ANG_STEPS];
  logic signed [KW-1:0]        cy_q [2][ANG_STEPS];
  logic signed [ANG_WIDTH-1:0] cz_q [2][ANG_STEPS];
  logic signed [KW-1:0]        cx_d [2][ANG_STEPS];
  logic signed [KW-1:0]        cy_d [2][ANG_STEPS];
  logic signed [ANG_WIDTH-1:0] cz_d [2][ANG_STEPS];

  always_comb begin
    logic signed [KW-1:0]        xi, yi;
    logic signed [ANG_WIDTH-1:0] zi;
    for (int bx = 0; bx < 2; bx++) begin
      for (int k = 0; k < ANG_STEPS; k++) begin
        if (k == 0) begin
          xi = KW'(h_q[bx]) <<< CORDIC_PRE_SHIFT;
          yi = KW'(w_q[bx]) <<< CORDIC_PRE_SHIFT;
          zi = '0;
        end else begin
          xi = cx_q[bx][k-1];
          yi = cy_q[bx][k-1];
          zi = cz_q[bx][k-1];
        end
        // rotate toward the x axis, accumulate the angle
        if (!yi[KW-1]) begin
          cx_d[bx][k] = xi + (yi >>> k);
          cy_d[bx][k] = yi - (xi >>> k);
          cz_d[bx][k] = zi + ATAN_TAB[k];
        end else begin
          cx_d[bx][k] = xi - (yi >>> k);
          cy_d[bx][k] = yi + (xi >>> k);
          cz_d[bx][k] = zi - ATAN_TAB[k];
        end
      end
    end
  end

  logic signed [ANG_WIDTH-1:0] dz_q;
  logic signed [DSW-1:0]       dsq_q;
  logic [VW-1:0]               v_q;
  logic [VW-1:0]               v_dly_q [V_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      dz_q   <= cz_q[1][ANG_STEPS-1] - cz_q[0][ANG_STEPS-1];
      dsq_q  <= DSW'(dz_q) * DSW'(dz_q);
      v_q    <= VW'(dsq_q >>> VSHIFT);
      // hold the aspect term until the IoU quotient arrives
      v_dly_q[0] <= v_q;
      for (int k = 1; k < V_DLY; k++) begin
        v_dly_q[k] <= v_dly_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- CIoU alpha stage
  logic [VW-1:0]          vd;
  logic signed [QB+1:0]   sa_d;
  logic signed [QB+1:0]   sa_q [LAT+1];
  logic signed [QB+2:0]   den3;
  logic [QB+1:0]          d3_d, d3_q;
  logic [2*VW-1:0]        n3_q;

  assign vd = v_dly_q[V_DLY-1];

  always_comb begin
    if (variant_q == VAR_IOU) begin
      sa_d = (QB+2)'(q1);
    end else begin
      sa_d = (QB+2)'(q1) - (QB+2)'(q2);
    end
    den3 = $signed((QB+3)'(vd)) - (QB+3)'(q1)
         + ((QB+3)'(1) <<< SCORE_FRAC_BITS) + $signed((QB+3)'(guard_eff));
    d3_d = (den3[QB+2] || den3 == '0) ? (QB+2)'(1) : (QB+2)'(den3);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n3_q     <= (2*VW)'(vd) * (2*VW)'(vd);
      d3_q     <= d3_d;
      sa_q[0]  <= sa_d;
      for (int k = 1; k <= LAT; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
    end
  end

  bos_div #(
    .NUM_WIDTH (2 * VW),
    .DEN_WIDTH (QB + 2),
    .FRAC_BITS (0)
  ) u_div_alpha (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n3_q),
    .neg_i (1'b0),
    .den_i (d3_q),
    .quo_o (q3)
  );

  // ---------------------------------------------------------------- final score
  logic signed [FW-1:0] fin;

  always_comb begin
    if (variant_q == VAR_CIOU) begin
      fin = FW'(sa_q[LAT]) - FW'(q3);
    end else begin
      fin = FW'(sa_q[LAT]);
    end
    if (fin > SAT_HI) begin
      sat_score = OW'(SAT_HI);
    end else if (fin < SAT_LO) begin
      sat_score = OW'(SAT_LO);
    end else begin
      sat_score = OW'(fin);
    end
  end

endmodule
